>>> src/aplib_lz_decompressor_macros.svh
// Assertion macros for the aPLib-style LZ decompressor checker.
// Included by the checker file; depends on nothing else.
`ifndef APLIB_LZ_DECOMPRESSOR_MACROS_SVH
`define APLIB_LZ_DECOMPRESSOR_MACROS_SVH

// Clocked implication, disabled during reset.
`define ALZ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Signal holds its value in the cycle after cond.
`define ALZ_ASSERT_STABLE(label, clk, rst_n, cond, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> $stable(sig)) \
    else $error(msg);

`endif

>>> src/alz_pkg.sv
// Package for the aPLib-style LZ decompressor: widths, decode phases,
// status codes, controller state encoding and command/status structs.
package alz_pkg;

  localparam int unsigned WinDepth  = 65536;
  localparam int unsigned WinAw     = 16;
  localparam int unsigned BurstLimit = 64;
  localparam int unsigned ByteCap   = (BurstLimit > 1) ? BurstLimit - 1 : 1;
  localparam int unsigned CntW      = 7;
  localparam logic [23:0] Mask24    = 24'hFFFFFF;
  localparam logic [23:0] LimitReset = 24'd65536;

  typedef enum logic [4:0] {
    PH_LEAD    = 5'd0,
    PH_TYPE    = 5'd1,
    PH_KIND2   = 5'd2,
    PH_KIND3   = 5'd3,
    PH_NIB     = 5'd4,
    PH_GA_BIT  = 5'd5,
    PH_GA_MORE = 5'd6,
    PH_GB_BIT  = 5'd7,
    PH_GB_MORE = 5'd8,
    PH_GC_BIT  = 5'd9,
    PH_GC_MORE = 5'd10,
    PH_LIT     = 5'd11,
    PH_OFF7    = 5'd12,
    PH_OFFHI   = 5'd13,
    PH_COPY    = 5'd14,
    PH_ZERO    = 5'd15
  } phase_e;

  typedef enum logic [1:0] {
    ST_BYTE  = 2'd0,
    ST_DONE  = 2'd1,
    ST_FAIL  = 2'd2,
    ST_PAUSE = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_STEP  = 5'b00010,
    S_READ  = 5'b00100,
    S_EMIT  = 5'b01000,
    S_DONE  = 5'b10000
  } ctl_state_e;

  // Controller -> datapath
  typedef struct packed {
    logic start;    // latch the accepted item and apply its byte
    logic step;     // evaluate one step of the decode loop
    logic emit_ack; // pending result register was taken
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic busy_done;  // run loop has returned for this item
    logic res_valid;  // a result is sitting in the result register
    logic res_show;   // held result is known final or followed, may be sent
  } dp_stat_t;

endpackage

>>> src/alz_datapath.sv
// Datapath of the LZ decompressor: decode state, history window memory and
// result register. Depends on alz_pkg; driven by alz_ctrl commands.
module alz_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [23:0]       limit_i,
  input  logic              in_kind_i,
  input  logic [7:0]        in_byte_i,
  input  logic              in_end_i,
  input  alz_pkg::dp_cmd_t  cmd_i,
  output alz_pkg::dp_stat_t stat_o,
  output logic [7:0]        res_byte_o,
  output logic [1:0]        res_status_o,
  output logic [23:0]       res_count_o,
  output logic              res_last_o
);

  alz_pkg::phase_e phase_q, phase_d;
  logic [7:0]  tag_q, tag_d;
  logic        tfirst_q, tfirst_d;  // fresh tag byte, top bit not yet used
  logic [23:0] len_q, len_d, off_q, off_d, prev_q, prev_d;
  logic        lits_q, lits_d;
  logic [23:0] wpos_q, wpos_d, crem_q, crem_d;
  logic [1:0]  fin_q, fin_d;
  logic        srcd_q, srcd_d;
  logic [alz_pkg::CntW-1:0] nres_q, nres_d;
  logic        run_q, run_d;      // run loop active
  logic        rdwait_q, rdwait_d; // memory read data valid next cycle
  logic        rv_q, rv_d;
  logic [7:0]  rb_q, rb_d;
  logic [1:0]  rs_q, rs_d;
  logic [23:0] rc_q, rc_d;
  logic        rl_q, rl_d;
  logic        blk;               // step wants a result slot that is taken

  logic [7:0] mem_q [alz_pkg::WinDepth];
  logic [7:0] rdata_q;
  logic       we;
  logic [alz_pkg::WinAw-1:0] waddr, raddr;
  logic [7:0] wdata;
  logic       re;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (re) rdata_q <= mem_q[raddr];
  end

  function automatic logic [23:0] sat24(input logic [24:0] v);
    return v[24] ? alz_pkg::Mask24 : v[23:0];
  endfunction

  always_comb begin
    logic [23:0] v;
    logic [24:0] ext;
    logic        put;
    logic [7:0]  pb;
    logic [1:0]  ps;
    logic        bit_v;
    logic        chk_fail;
    logic        do_copy;
    logic [23:0] clen, coff;
    logic        stopped;
    v = '0; ext = '0; put = 1'b0; pb = '0; ps = alz_pkg::ST_BYTE; bit_v = 1'b0;
    chk_fail = 1'b0; do_copy = 1'b0; clen = '0; coff = '0; stopped = 1'b0;
    phase_d = phase_q; tag_d = tag_q; len_d = len_q; off_d = off_q;
    prev_d = prev_q; lits_d = lits_q; wpos_d = wpos_q; crem_d = crem_q;
    fin_d = fin_q; srcd_d = srcd_q; nres_d = nres_q; run_d = run_q;
    tfirst_d = tfirst_q;
    rdwait_d = 1'b0;
    rv_d = rv_q; rb_d = rb_q; rs_d = rs_q; rc_d = rc_q; rl_d = rl_q;
    we = 1'b0; waddr = wpos_q[alz_pkg::WinAw-1:0]; wdata = '0;
    re = 1'b0; raddr = wpos_q[alz_pkg::WinAw-1:0] - off_q[alz_pkg::WinAw-1:0];
    blk = 1'b0;
    if (cmd_i.emit_ack) rv_d = 1'b0;

    if (cmd_i.start) begin
      nres_d = '0;
      run_d = 1'b0;
      if (fin_q != 2'd0) begin
        put = 1'b1; ps = fin_q; stopped = 1'b1;
      end else if (in_kind_i) begin
        run_d = (phase_q == alz_pkg::PH_COPY) || (phase_q == alz_pkg::PH_ZERO);
      end else if (!((phase_q == alz_pkg::PH_COPY) || (phase_q == alz_pkg::PH_ZERO))) begin
        run_d = 1'b1;
        if (in_end_i) srcd_d = 1'b1;
        case (phase_q)
          alz_pkg::PH_LEAD, alz_pkg::PH_LIT: begin
            if (phase_q == alz_pkg::PH_LEAD && wpos_q >= limit_i) begin
              fin_d = alz_pkg::ST_FAIL; put = 1'b1; ps = alz_pkg::ST_FAIL;
            end else begin
              we = 1'b1; wdata = in_byte_i; wpos_d = wpos_q + 24'd1;
              put = 1'b1; pb = in_byte_i; lits_d = 1'b1;
              phase_d = alz_pkg::PH_TYPE;
            end
          end
          alz_pkg::PH_OFF7: begin
            if (in_byte_i[7:1] == 7'd0) begin
              fin_d = alz_pkg::ST_DONE; put = 1'b1; ps = alz_pkg::ST_DONE;
            end else begin
              prev_d = {17'd0, in_byte_i[7:1]}; lits_d = 1'b0;
              do_copy = 1'b1; clen = {22'd0, 1'b1, in_byte_i[0]};
              coff = {17'd0, in_byte_i[7:1]};
            end
          end
          alz_pkg::PH_OFFHI: begin
            off_d = (off_q[23:16] != 8'd0) ? alz_pkg::Mask24 : {off_q[15:0], in_byte_i};
            len_d = 24'd1; phase_d = alz_pkg::PH_GC_BIT;
          end
          default: begin
            if (in_end_i) begin
              fin_d = alz_pkg::ST_FAIL; put = 1'b1; ps = alz_pkg::ST_FAIL;
            end else begin
              // top bit is applied on the first step, then a marker 1 fills in
              tag_d = in_byte_i;
              tfirst_d = 1'b1;
            end
          end
        endcase
      end
    end else if (cmd_i.step) begin
      if (rdwait_q) begin
        we = 1'b1; wdata = rdata_q; wpos_d = wpos_q + 24'd1;
        crem_d = crem_q - 24'd1; put = 1'b1; pb = rdata_q;
      end else if (fin_q != 2'd0) begin
        run_d = 1'b0;
      end else begin
        case (phase_q)
          alz_pkg::PH_COPY: begin
            if (crem_q == 24'd0) phase_d = alz_pkg::PH_TYPE;
            else if (32'(nres_q) >= alz_pkg::ByteCap) begin
              put = 1'b1; ps = alz_pkg::ST_PAUSE; run_d = 1'b0;
            end else begin
              re = 1'b1; rdwait_d = 1'b1;
            end
          end
          alz_pkg::PH_ZERO: begin
            if (32'(nres_q) >= alz_pkg::ByteCap) begin
              put = 1'b1; ps = alz_pkg::ST_PAUSE; run_d = 1'b0;
            end else begin
              we = 1'b1; wdata = 8'd0; wpos_d = wpos_q + 24'd1;
              put = 1'b1; phase_d = alz_pkg::PH_TYPE;
            end
          end
          alz_pkg::PH_LEAD, alz_pkg::PH_LIT, alz_pkg::PH_OFF7, alz_pkg::PH_OFFHI: begin
            run_d = 1'b0;
            if (srcd_q) begin
              fin_d = alz_pkg::ST_FAIL; put = 1'b1; ps = alz_pkg::ST_FAIL;
            end
          end
          default: begin
            if (!tfirst_q && tag_q[6:0] == 7'd0) begin
              run_d = 1'b0;
              if (srcd_q) begin
                fin_d = alz_pkg::ST_FAIL; put = 1'b1; ps = alz_pkg::ST_FAIL;
              end
            end else begin
              bit_v = tag_q[7];
              tag_d = {tag_q[6:0], tfirst_q};
              tfirst_d = 1'b0;
              case (phase_q)
                alz_pkg::PH_TYPE: begin
                  if (bit_v) phase_d = alz_pkg::PH_KIND2;
                  else if (wpos_q >= limit_i) begin
                    fin_d = alz_pkg::ST_FAIL; put = 1'b1; ps = alz_pkg::ST_FAIL;
                  end else phase_d = alz_pkg::PH_LIT;
                end
                alz_pkg::PH_KIND2: begin
                  if (bit_v) phase_d = alz_pkg::PH_KIND3;
                  else begin len_d = 24'd1; phase_d = alz_pkg::PH_GA_BIT; end
                end
                alz_pkg::PH_KIND3: begin
                  if (bit_v) begin
                    lits_d = 1'b1; off_d = 24'h10; phase_d = alz_pkg::PH_NIB;
                  end else phase_d = alz_pkg::PH_OFF7;
                end
                alz_pkg::PH_NIB: begin
                  v = {off_q[22:0], bit_v};
                  off_d = v;
                  if (v[8]) begin
                    if (v[7:0] == 8'd0) begin
                      if (wpos_q >= limit_i) begin
                        fin_d = alz_pkg::ST_FAIL; put = 1'b1; ps = alz_pkg::ST_FAIL;
                      end else phase_d = alz_pkg::PH_ZERO;
                    end else begin
                      do_copy = 1'b1; clen = 24'd1; coff = {16'd0, v[7:0]};
                    end
                  end
                end
                alz_pkg::PH_GA_BIT, alz_pkg::PH_GB_BIT, alz_pkg::PH_GC_BIT: begin
                  len_d = sat24({len_q, bit_v});
                  phase_d = alz_pkg::phase_e'(phase_q + 5'd1);
                end
                alz_pkg::PH_GA_MORE: begin
                  if (bit_v) phase_d = alz_pkg::PH_GA_BIT;
                  else begin
                    v = len_q - 24'd1 - {23'd0, lits_q};
                    if (v == 24'd0) begin
                      len_d = 24'd1; phase_d = alz_pkg::PH_GB_BIT;
                    end else begin
                      off_d = v - 24'd1; phase_d = alz_pkg::PH_OFFHI;
                    end
                  end
                end
                alz_pkg::PH_GB_MORE: begin
                  if (bit_v) phase_d = alz_pkg::PH_GB_BIT;
                  else begin
                    lits_d = 1'b0; do_copy = 1'b1; clen = len_q; coff = prev_q;
                  end
                end
                alz_pkg::PH_GC_MORE: begin
                  if (bit_v) phase_d = alz_pkg::PH_GC_BIT;
                  else begin
                    v = len_q;
                    if (off_q >= 24'h7d00) v = sat24({1'b0, v} + 25'd1);
                    if (off_q >= 24'h500)  v = sat24({1'b0, v} + 25'd1);
                    if (off_q <= 24'h7f)   v = sat24({1'b0, v} + 25'd2);
                    prev_d = off_q; lits_d = 1'b0;
                    do_copy = 1'b1; clen = v; coff = off_q;
                  end
                end
                default: phase_d = alz_pkg::PH_TYPE;
              endcase
            end
          end
        endcase
      end
    end

    if (do_copy) begin
      ext = {1'b0, wpos_q} + {1'b0, clen};
      chk_fail = (clen == 24'd0) || (coff == 24'd0) || (coff > wpos_q) ||
                 ({1'b0, coff} > 25'(alz_pkg::WinDepth)) || (ext > {1'b0, limit_i});
      if (chk_fail) begin
        fin_d = alz_pkg::ST_FAIL; put = 1'b1; ps = alz_pkg::ST_FAIL;
      end else begin
        crem_d = clen; off_d = coff; phase_d = alz_pkg::PH_COPY;
      end
    end
    if (put && ps == alz_pkg::ST_FAIL) stopped = 1'b1;
    if (put && ps == alz_pkg::ST_DONE) stopped = 1'b1;
    if (stopped) run_d = 1'b0;

    // the next result is due while the previous one is still held: the step
    // is dropped and repeated once the held result has been taken
    blk = cmd_i.step && put && rv_q;
    if (blk) begin
      phase_d = phase_q; tag_d = tag_q; tfirst_d = tfirst_q; len_d = len_q;
      off_d = off_q; prev_d = prev_q; lits_d = lits_q; wpos_d = wpos_q;
      crem_d = crem_q; fin_d = fin_q; srcd_d = srcd_q; nres_d = nres_q;
      run_d = run_q; rdwait_d = rdwait_q; we = 1'b0; re = 1'b0; put = 1'b0;
    end

    if (put) begin
      rv_d = 1'b1; rb_d = pb; rs_d = ps; rc_d = wpos_d;
      rl_d = !run_d;
      nres_d = nres_q + 7'd1;
    end else if (rv_q && run_q && !run_d) begin
      // loop ended without another result: the held one closes the item
      rl_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= alz_pkg::PH_LEAD; tag_q <= 8'h80; len_q <= '0; off_q <= '0;
      prev_q <= '0; lits_q <= 1'b1; wpos_q <= '0; crem_q <= '0; fin_q <= '0;
      srcd_q <= 1'b0; nres_q <= '0; run_q <= 1'b0; rdwait_q <= 1'b0; rv_q <= 1'b0;
      tfirst_q <= 1'b0;
    end else begin
      phase_q <= phase_d; tag_q <= tag_d; len_q <= len_d; off_q <= off_d;
      prev_q <= prev_d; lits_q <= lits_d; wpos_q <= wpos_d; crem_q <= crem_d;
      fin_q <= fin_d; srcd_q <= srcd_d; nres_q <= nres_d; run_q <= run_d;
      rdwait_q <= rdwait_d; rv_q <= rv_d;
      tfirst_q <= tfirst_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rb_q <= rb_d; rs_q <= rs_d; rc_q <= rc_d; rl_q <= rl_d;
  end

  // a held result goes out once it is known to be last, or once the next
  // result is waiting behind it
  assign stat_o.busy_done = !run_q && !rdwait_q;
  assign stat_o.res_valid = rv_q;
  assign stat_o.res_show  = rv_q && (rl_q || blk);
  assign res_byte_o   = rb_q;
  assign res_status_o = rs_q;
  assign res_count_o  = rc_q;
  assign res_last_o   = rl_q;

endmodule

>>> src/alz_ctrl.sv
// Controller of the LZ decompressor: input handshake, run sequencing and
// result handshake. Depends on alz_pkg; commands alz_datapath.
module alz_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  input  alz_pkg::dp_stat_t stat_i,
  output alz_pkg::dp_cmd_t  cmd_o
);

  alz_pkg::ctl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = stat_i.res_show;
    cmd_o.emit_ack = stat_i.res_show && out_ready_i;
    case (state_q)
      alz_pkg::S_IDLE: begin
        in_ready_o = !stat_i.res_valid;
        if (in_valid_i && !stat_i.res_valid) begin
          cmd_o.start = 1'b1; state_d = alz_pkg::S_STEP;
        end
      end
      alz_pkg::S_STEP: begin
        if (stat_i.busy_done) state_d = alz_pkg::S_IDLE;
        else cmd_o.step = 1'b1;
      end
      default: state_d = alz_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= alz_pkg::S_IDLE;
    else state_q <= state_d;
  end

endmodule

>>> src/aplib_lz_decompressor.sv
// Top level of the aPLib-style LZ decompressor: config register plus
// controller and datapath. Depends on alz_pkg, alz_ctrl, alz_datapath.
//
//  channel | dir | tdata fields (low bit up)            | tuser
//  s_axis  | in  | data_byte[7:0], source_end[8]        | kind
//  m_axis  | out | out_byte[7:0], status[9:8], count    | -
//                  [33:10], last_of_run as tlast
//  cfg     | in  | output_limit[23:0], written on cfg_we_i
//
// An item is accepted in the idle state; then one control bit of a tag byte is
// decoded per cycle, going on while a result is held and stalling only when the
// next result is due. A copied byte takes a memory read and then a write; at
// most 63 bytes per item before a pause result. Reset is asynchronous; the
// window RAM is not cleared, since a copy only reads bytes already written.
module aplib_lz_decompressor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [23:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // data_byte[7:0], source_end[8]
  input  logic        s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // out_byte, status, out_count
  output logic        m_axis_tlast    // last_of_run
);

  logic [23:0] limit_q;
  alz_pkg::dp_cmd_t  cmd;
  alz_pkg::dp_stat_t stat;
  logic [7:0]  rb;
  logic [1:0]  rs;
  logic [23:0] rc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) limit_q <= alz_pkg::LimitReset;
    else if (cfg_we_i) limit_q <= cfg_wdata_i;
  end

  alz_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid), .in_ready_o (s_axis_tready),
    .out_ready_i(m_axis_tready), .out_valid_o(m_axis_tvalid),
    .stat_i(stat), .cmd_o(cmd)
  );

  alz_datapath u_dp (
    .clk_i, .rst_ni, .limit_i(limit_q),
    .in_kind_i(s_axis_tuser), .in_byte_i(s_axis_tdata[7:0]),
    .in_end_i(s_axis_tdata[8]), .cmd_i(cmd), .stat_o(stat),
    .res_byte_o(rb), .res_status_o(rs), .res_count_o(rc), .res_last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, rc, rs, rb};

endmodule

>>> src/alz_checker.sv
// Port-level checker for the LZ decompressor, bound to the top level.
// Depends on aplib_lz_decompressor_macros.svh.
`include "aplib_lz_decompressor_macros.svh"
module alz_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  `ALZ_ASSERT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "out dropped")
  `ALZ_ASSERT_STABLE(a_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tdata, "out changed")
  `ALZ_ASSERT(a_nobyte, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[9:8] != 2'd0 |-> m_axis_tdata[7:0] == 8'd0, "byte on status")
  `ALZ_ASSERT(a_idle, clk_i, rst_ni, m_axis_tvalid |-> !(s_axis_tvalid && s_axis_tready), "accept while result pending")
  `ALZ_ASSERT(a_last, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[9:8] != 2'd0 |-> m_axis_tlast, "status not last")
endmodule

bind aplib_lz_decompressor alz_checker u_chk (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
);
